@@ design/lbed_pkg.sv @@
// Shared constants and register codes for the lidar body edge distance pipeline.
// Used by the other RTL files except lbed_div; no dependencies.
package lbed_pkg;

	// angles in units of 2^-24 rad
	localparam logic [26:0] TWO_PI     = 27'd105414357;
	localparam logic [26:0] HALF_PI    = 27'd26353589;
	localparam logic [26:0] QUARTER_PI = 27'd13176795;

	// Q30 unity
	localparam logic [30:0] Q30_ONE = 31'h40000000;

	// Horner divisors, innermost term first
	localparam int unsigned SIN_DIV [4] = '{72, 42, 20, 6};
	localparam int unsigned COS_DIV [4] = '{90, 56, 30, 12};

	localparam int MAX_BEAMS_DEF = 2048;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CAR_WIDTH    = 3'd0,
		REG_WHEEL_BASE   = 3'd1,
		REG_LIDAR_OFFSET = 3'd2,
		REG_ANGLE_START  = 3'd3,
		REG_ANGLE_STEP   = 3'd4
	} reg_index_t;

endpackage

@@ design/lidar_beam_body_edge_distance.sv @@
// Lidar beam to body edge distance, 28 register stages, one request per cycle.
// Part of the depth comes from the two four-step Horner chains (multiply, reciprocal, fix-up).
// Throughput: one request per cycle; a stall at the output freezes every stage.
// Reset: arst_n clears all valid bits and the configuration registers to zero.
// Depends on lbed_pkg, lbed_angle, lbed_trig, lbed_div.
module lidar_beam_body_edge_distance #(
	parameter int MAX_BEAMS = lbed_pkg::MAX_BEAMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_enable,
	input  logic [2:0]  reg_index,
	input  logic [26:0] write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [10:0] beam_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] beam_number,
	output logic [19:0] edge_distance,
	output logic        saturated
);

	// per-request sideband carried alongside the datapath
	typedef struct packed {
		logic [10:0] idx;
		logic        oob;
		logic        a_pos;
		logic        fwd;
	} side_t;

	localparam int          DEPTH    = 27;
	localparam logic [19:0] DIST_MAX = 20'hFFFFF;
	localparam logic signed [37:0] HP = 38'(lbed_pkg::HALF_PI);

	// configuration
	logic [15:0] car_width_q;
	logic [15:0] wheel_base_q;
	logic [15:0] lidar_offset_q;
	logic [26:0] angle_start_q;
	logic [24:0] angle_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_width_q    <= '0;
			wheel_base_q   <= '0;
			lidar_offset_q <= '0;
			angle_start_q  <= '0;
			angle_step_q   <= '0;
		end else if (write_enable) begin
			case (lbed_pkg::reg_index_t'(reg_index))
				lbed_pkg::REG_CAR_WIDTH:    car_width_q    <= write_data[15:0];
				lbed_pkg::REG_WHEEL_BASE:   wheel_base_q   <= write_data[15:0];
				lbed_pkg::REG_LIDAR_OFFSET: lidar_offset_q <= write_data[15:0];
				lbed_pkg::REG_ANGLE_START:  angle_start_q  <= write_data;
				lbed_pkg::REG_ANGLE_STEP:   angle_step_q   <= write_data[24:0];
				default: ;
			endcase
		end
	end

	// whole pipe advances unless the output holds an untaken result
	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// valid bits and sideband, entry k belongs to stage k+1
	logic [DEPTH-1:0] vld_q;
	side_t            side_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[DEPTH-2:0], in_valid};
			out_valid_q <= vld_q[DEPTH-1];
		end
	end

	// stage 1: beam angle = start + index * step
	logic [35:0]        step_prod;
	logic signed [37:0] angle_c;
	logic signed [37:0] angle_s1;
	side_t              side_c;

	assign step_prod = {25'd0, beam_index} * {11'd0, angle_step_q};
	assign angle_c   = $signed({{11{angle_start_q[26]}}, angle_start_q})
		+ $signed({2'b00, step_prod});

	always_comb begin
		side_c.idx   = beam_index;
		side_c.oob   = (32'(beam_index) >= 32'(MAX_BEAMS));
		side_c.a_pos = !angle_c[37] && (angle_c != 38'sd0);
		// beam points forward within plus or minus a quarter turn
		side_c.fwd   = side_c.a_pos ? (angle_c <= HP) : (angle_c >= -HP);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s1  <= angle_c;
			side_q[0] <= side_c;
			for (int k = 1; k < DEPTH; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// stages 2-4: reduce to [0, 2pi)
	logic [26:0] reduced;

	lbed_angle u_angle (
		.clk    (clk),
		.en     (en),
		.angle  (angle_s1),
		.reduced(reduced)
	);

	// stages 5-20: signed Q30 sine and cosine
	logic signed [31:0] sine;
	logic signed [31:0] cosine;

	lbed_trig u_trig (
		.clk    (clk),
		.en     (en),
		.reduced(reduced),
		.sine   (sine),
		.cosine (cosine)
	);

	// stage 21: pick side and end divisors and numerators
	logic [15:0]        front;
	logic [15:0]        endnum;
	logic [45:0]        num_side_s21;
	logic [45:0]        num_end_s21;
	logic signed [31:0] d_side_s21;
	logic signed [31:0] d_end_s21;

	// lidar ahead of the front edge clamps the front distance at zero
	assign front  = (wheel_base_q > lidar_offset_q) ? (wheel_base_q - lidar_offset_q) : 16'd0;
	assign endnum = side_q[19].fwd ? front : lidar_offset_q;

	always_ff @(posedge clk) begin
		if (en) begin
			num_side_s21 <= {1'b0, car_width_q, 29'd0};
			num_end_s21  <= {endnum, 30'd0};
			d_side_s21   <= side_q[19].a_pos ? sine : -sine;
			d_end_s21    <= side_q[19].fwd ? cosine : -cosine;
		end
	end

	// stages 22-27: the two quotients
	logic [20:0] q_side;
	logic [20:0] q_end;

	lbed_div u_div_side (
		.clk (clk),
		.en  (en),
		.num (num_side_s21),
		.den (d_side_s21),
		.quot(q_side)
	);

	lbed_div u_div_end (
		.clk (clk),
		.en  (en),
		.num (num_end_s21),
		.den (d_end_s21),
		.quot(q_end)
	);

	// stage 28: lesser distance, saturation, output register
	logic [20:0] best;
	logic [10:0] beam_s28;
	logic [19:0] dist_s28;
	logic        sat_s28;

	assign best = (q_side < q_end) ? q_side : q_end;

	always_ff @(posedge clk) begin
		if (en) begin
			beam_s28 <= side_q[DEPTH-1].idx;
			if (side_q[DEPTH-1].oob) begin
				dist_s28 <= 20'd0;
				sat_s28  <= 1'b0;
			end else if (best > {1'b0, DIST_MAX}) begin
				dist_s28 <= DIST_MAX;
				sat_s28  <= 1'b1;
			end else begin
				dist_s28 <= best[19:0];
				sat_s28  <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign beam_number   = beam_s28;
	assign edge_distance = dist_s28;
	assign saturated     = sat_s28;

`ifndef SYNTHESIS
	// a clipped result always reads full scale
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (edge_distance == DIST_MAX))
		else $error("saturated result without full-scale distance");

	// beams beyond the table give zero and no clip
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (32'(beam_number) >= 32'(MAX_BEAMS)))
		|-> ((edge_distance == 20'd0) && !saturated))
		else $error("out-of-range beam gave a distance");

	// the last pipeline stage reaches the output when the pipe moves
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DEPTH-1] && en) |=> out_valid)
		else $error("request lost at output stage");
`endif

endmodule

@@ design/lbed_angle.sv @@
// Floor modulo of a signed beam angle by two pi, three register stages.
// Depends on lbed_pkg.
module lbed_angle (
	input  logic               clk,
	input  logic               en,
	input  logic signed [37:0] angle,
	output logic        [26:0] reduced
);

	localparam logic [36:0] TP = 37'(lbed_pkg::TWO_PI);

	// five restoring steps, multiples TP<<hi down to TP<<(hi-4)
	function automatic logic [36:0] reduce5(input logic [36:0] rem_in, input int hi);
		logic [36:0] rem;
		logic [36:0] sub;
		rem = rem_in;
		for (int i = 0; i < 5; i++) begin
			sub = TP << (hi - i);
			if (rem >= sub) begin
				rem = rem - sub;
			end
		end
		return rem;
	endfunction

	logic [36:0] mag;
	logic [36:0] rem_s1;
	logic [36:0] rem_s2;
	logic        neg_s1;
	logic        neg_s2;
	logic [26:0] r_s3;
	logic [26:0] m27;

	assign mag = angle[37] ? 37'(-angle) : angle[36:0];
	assign m27 = rem_s2[26:0];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= reduce5(mag, 9);
			neg_s1 <= angle[37];
			rem_s2 <= reduce5(rem_s1, 4);
			neg_s2 <= neg_s1;
			if (neg_s2 && (m27 != 27'd0)) begin
				r_s3 <= lbed_pkg::TWO_PI - m27;
			end else begin
				r_s3 <= m27;
			end
		end
	end

	assign reduced = r_s3;

endmodule

@@ design/lbed_hstep.sv @@
// One Horner step: t_out = 1 - floor(((x2 * t_in) >> 30) / DIVISOR) in Q30.
// Three stages: product, reciprocal product, correction. Depends on lbed_pkg.
module lbed_hstep #(
	parameter int unsigned DIVISOR = 6
) (
	input  logic        clk,
	input  logic        en,
	input  logic [29:0] x2_in,
	input  logic [30:0] t_in,
	output logic [29:0] x2_out,
	output logic [30:0] t_out
);

	localparam longint unsigned RECIP_L = (64'd1 << 32) / DIVISOR;
	localparam logic [31:0] RECIP = 32'(RECIP_L);
	localparam logic [31:0] DIV32 = 32'(DIVISOR);

	logic [60:0] prod1;
	logic [61:0] prod2;
	logic [29:0] p_s1, p_s2;
	logic [29:0] q0_s2;
	logic [29:0] x2_s1, x2_s2, x2_s3;
	logic [30:0] t_s3;
	logic [31:0] qd;
	logic [31:0] rem;
	logic [29:0] qf;

	assign prod1 = x2_in * t_in;
	assign prod2 = p_s1 * RECIP;
	// estimate is exact or one low
	assign qd  = {2'b00, q0_s2} * DIV32;
	assign rem = {2'b00, p_s2} - qd;
	assign qf  = q0_s2 + 30'(rem >= DIV32);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= prod1[59:30];
			x2_s1 <= x2_in;
			q0_s2 <= prod2[61:32];
			p_s2  <= p_s1;
			x2_s2 <= x2_s1;
			t_s3  <= lbed_pkg::Q30_ONE - {1'b0, qf};
			x2_s3 <= x2_s2;
		end
	end

	assign x2_out = x2_s3;
	assign t_out  = t_s3;

endmodule

@@ design/lbed_trig.sv @@
// Signed Q30 sine and cosine of a reduced angle, sixteen register stages.
// Depends on lbed_pkg and lbed_hstep.
module lbed_trig (
	input  logic               clk,
	input  logic               en,
	input  logic        [26:0] reduced,
	output logic signed [31:0] sine,
	output logic signed [31:0] cosine
);

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic [29:0] x30;
		quad_t       quad;
		logic        swap;
	} meta_t;

	localparam logic [26:0] H  = lbed_pkg::HALF_PI;
	localparam logic [26:0] H2 = 27'(2 * lbed_pkg::HALF_PI);
	localparam logic [26:0] H3 = 27'(3 * lbed_pkg::HALF_PI);

	quad_t       quad_c;
	logic [26:0] rr;
	logic [26:0] xf;
	logic        swap_c;
	meta_t       meta_q [15];

	always_comb begin
		if (reduced >= H3) begin
			quad_c = QUAD_3;
			rr     = reduced - H3;
		end else if (reduced >= H2) begin
			quad_c = QUAD_2;
			rr     = reduced - H2;
		end else if (reduced >= H) begin
			quad_c = QUAD_1;
			rr     = reduced - H;
		end else begin
			quad_c = QUAD_0;
			rr     = reduced;
		end
		// fold to the lower octant
		if (rr > lbed_pkg::QUARTER_PI) begin
			xf     = H - rr;
			swap_c = 1'b1;
		end else begin
			xf     = rr;
			swap_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[0] <= '{x30: {xf[23:0], 6'b0}, quad: quad_c, swap: swap_c};
			for (int k = 1; k < 15; k++) begin
				meta_q[k] <= meta_q[k-1];
			end
		end
	end

	logic [59:0] sq;
	logic [29:0] x2_s2;

	assign sq = meta_q[0].x30 * meta_q[0].x30;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2 <= sq[59:30];
		end
	end

	// Horner chains, first step runs with t = 1
	logic [29:0] sx2 [5];
	logic [30:0] st  [5];
	logic [29:0] cx2 [5];
	logic [30:0] ct  [5];

	assign sx2[0] = x2_s2;
	assign st[0]  = lbed_pkg::Q30_ONE;
	assign cx2[0] = x2_s2;
	assign ct[0]  = lbed_pkg::Q30_ONE;

	for (genvar g = 0; g < 4; g++) begin : g_horner
		lbed_hstep #(.DIVISOR(lbed_pkg::SIN_DIV[g])) u_sin_step (
			.clk   (clk),
			.en    (en),
			.x2_in (sx2[g]),
			.t_in  (st[g]),
			.x2_out(sx2[g+1]),
			.t_out (st[g+1])
		);
		lbed_hstep #(.DIVISOR(lbed_pkg::COS_DIV[g])) u_cos_step (
			.clk   (clk),
			.en    (en),
			.x2_in (cx2[g]),
			.t_in  (ct[g]),
			.x2_out(cx2[g+1]),
			.t_out (ct[g+1])
		);
	end

	logic [60:0] sprod;
	logic [60:0] cprod;
	logic [29:0] s_s15;
	logic [29:0] mc_s15;
	logic [30:0] s31;
	logic [30:0] c31;
	logic [30:0] ps;
	logic [30:0] pc;
	logic signed [31:0] sn_c;
	logic signed [31:0] cs_c;
	logic signed [31:0] sn_s16;
	logic signed [31:0] cs_s16;

	// sx2[4] is the delayed square, not needed past the last sine step
	assign sprod = meta_q[13].x30 * st[4];
	assign cprod = cx2[4] * ct[4];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s15  <= sprod[59:30];
			mc_s15 <= cprod[59:30];
		end
	end

	assign s31 = {1'b0, s_s15};
	assign c31 = lbed_pkg::Q30_ONE - {2'b00, mc_s15[29:1]};
	assign ps  = meta_q[14].swap ? c31 : s31;
	assign pc  = meta_q[14].swap ? s31 : c31;

	always_comb begin
		case (meta_q[14].quad)
			QUAD_0: begin
				sn_c = $signed({1'b0, ps});
				cs_c = $signed({1'b0, pc});
			end
			QUAD_1: begin
				sn_c = $signed({1'b0, pc});
				cs_c = -$signed({1'b0, ps});
			end
			QUAD_2: begin
				sn_c = -$signed({1'b0, ps});
				cs_c = -$signed({1'b0, pc});
			end
			QUAD_3: begin
				sn_c = -$signed({1'b0, pc});
				cs_c = $signed({1'b0, ps});
			end
			default: begin
				sn_c = '0;
				cs_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s16 <= sn_c;
			cs_s16 <= cs_c;
		end
	end

	assign sine   = sn_s16;
	assign cosine = cs_s16;

endmodule

@@ design/lbed_div.sv @@
// Pipelined restoring divider, quotient clamped to 2^20, six register stages.
// Zero divisor saturates, negative divisor gives zero. No dependencies.
module lbed_div (
	input  logic               clk,
	input  logic               en,
	input  logic        [45:0] num,
	input  logic signed [31:0] den,
	output logic        [20:0] quot
);

	typedef enum logic [1:0] {
		DM_NORMAL = 2'd0,
		DM_SAT    = 2'd1,
		DM_ZERO   = 2'd2
	} div_mode_t;

	typedef struct packed {
		logic [50:0] rem;
		logic [19:0] q;
	} div_acc_t;

	function automatic div_acc_t steps4(input div_acc_t acc_in, input logic [30:0] dm,
		input int hi);
		div_acc_t    acc;
		logic [50:0] sub;
		acc = acc_in;
		for (int i = 0; i < 4; i++) begin
			sub = 51'(dm) << (hi - i);
			if (acc.rem >= sub) begin
				acc.rem       = acc.rem - sub;
				acc.q[hi - i] = 1'b1;
			end
		end
		return acc;
	endfunction

	div_mode_t   mode_c;
	div_acc_t    acc_s   [1:5];
	logic [30:0] dm_s    [1:5];
	div_mode_t   mode_s  [1:5];
	div_acc_t    last_c;
	logic [20:0] q_s6;

	always_comb begin
		if (den == 32'sd0) begin
			mode_c = DM_SAT;
		end else if (den[31]) begin
			mode_c = DM_ZERO;
		end else if (51'(num) >= (51'(den[30:0]) << 20)) begin
			mode_c = DM_SAT;
		end else begin
			mode_c = DM_NORMAL;
		end
	end

	assign last_c = steps4(acc_s[5], dm_s[5], 3);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[1]  <= '{rem: 51'(num), q: 20'd0};
			dm_s[1]   <= den[30:0];
			mode_s[1] <= mode_c;
			for (int j = 2; j <= 5; j++) begin
				acc_s[j]  <= steps4(acc_s[j-1], dm_s[j-1], 19 - 4 * (j - 2));
				dm_s[j]   <= dm_s[j-1];
				mode_s[j] <= mode_s[j-1];
			end
			case (mode_s[5])
				DM_SAT:    q_s6 <= 21'h100000;
				DM_ZERO:   q_s6 <= 21'd0;
				DM_NORMAL: q_s6 <= {1'b0, last_c.q};
				default:   q_s6 <= 21'd0;
			endcase
		end
	end

	assign quot = q_s6;

endmodule
